@@ src/nfa_symbol_stepper_macros.svh @@
// Assertion macros shared by the NFA stepper checker.
// Expects signals named clk and arst_n in the including scope.
`ifndef NFA_SYMBOL_STEPPER_MACROS_SVH
`define NFA_SYMBOL_STEPPER_MACROS_SVH

// checked only out of reset
`define NSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define NSS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/nss_pkg.sv @@
// Shared constants, codes and controller/datapath structs for the NFA stepper.
// No dependencies.
package nss_pkg;

	localparam int STATES      = 16;
	localparam int TRANSITIONS = 128;

	localparam int STATE_W  = 4;
	localparam int SYM_W    = 8;
	localparam int SLOT_W   = 7;
	localparam int OP_W     = 2;
	localparam int IN_USE_W = 8;
	localparam int CFG_AW   = 2;
	localparam int CFG_DW   = 16;
	localparam int ENTRY_W  = 2 * STATE_W + SYM_W;

	localparam int TR_AW = (TRANSITIONS > 1) ? $clog2(TRANSITIONS) : 1;
	localparam int CNT_W = $clog2(TRANSITIONS + 1);

	typedef enum logic [OP_W-1:0] {
		OP_WRITE   = 2'd0,
		OP_RESTART = 2'd1,
		OP_SYMBOL  = 2'd2,
		OP_NOP     = 2'd3
	} op_e_t;

	typedef enum logic [CFG_AW-1:0] {
		CFG_INITIAL = 2'd0,
		CFG_FINAL   = 2'd1,
		CFG_IN_USE  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic             accept;
		logic             ram_we;
		logic             restart;
		logic             rd_en;
		logic [TR_AW-1:0] rd_addr;
		logic             eval;
		logic             commit;
		logic             load_out;
	} nss_cmd_t;

	typedef struct packed {
		logic             limit_zero;
		logic [CNT_W-1:0] limit;
	} nss_stat_t;

	function automatic logic [STATES-1:0] state_bit(logic [STATE_W-1:0] s);
		logic [STATES-1:0] m;
		m = '0;
		if (32'(s) < STATES) begin
			m[s] = 1'b1;
		end
		return m;
	endfunction

endpackage

@@ src/nss_if.sv @@
// Channel interfaces: request, response and config write.
// Depends on nss_pkg.
interface nss_req_if;
	import nss_pkg::*;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [SLOT_W-1:0]   slot;
	logic [STATE_W-1:0]  from_state;
	logic [STATE_W-1:0]  to_state;
	logic [SYM_W-1:0]    entry_symbol;
	logic [SYM_W-1:0]    symbol;
	modport source (output valid, opcode, slot, from_state, to_state, entry_symbol, symbol,
		input ready);
	modport sink (input valid, opcode, slot, from_state, to_state, entry_symbol, symbol,
		output ready);
endinterface

interface nss_rsp_if;
	import nss_pkg::*;
	logic              valid;
	logic              ready;
	logic [STATES-1:0] active_states;
	logic              accepting;
	logic              dead;
	modport source (output valid, active_states, accepting, dead, input ready);
	modport sink (input valid, active_states, accepting, dead, output ready);
endinterface

interface nss_cfg_if;
	import nss_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] addr;
	logic [CFG_DW-1:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

@@ src/nss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ src/nss_ctrl.sv @@
// Controller FSM: accepts items, sequences the table scan, hands off results.
// Depends on nss_pkg.
module nss_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic [nss_pkg::OP_W-1:0] req_opcode,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  nss_pkg::nss_stat_t    stat,
	output nss_pkg::nss_cmd_t     cmd
);
	import nss_pkg::*;

	typedef enum logic [1:0] {IDLE, SCAN, DRAIN, EMIT} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             eval_q;
	logic             rsp_valid_q;
	logic             accept;
	logic             out_free;
	op_e_t            op;

	assign op        = op_e_t'(req_opcode);
	assign accept    = req_valid && (state_q == IDLE);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.accept   = accept;
		cmd.ram_we   = accept && (op == OP_WRITE);
		cmd.restart  = accept && (op == OP_RESTART);
		cmd.rd_en    = (state_q == SCAN);
		cmd.rd_addr  = cnt_q[TR_AW-1:0];
		cmd.eval     = eval_q;
		cmd.commit   = (state_q == DRAIN);
		cmd.load_out = (state_q == EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			cnt_q       <= '0;
			eval_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			eval_q <= (state_q == SCAN);
			if ((state_q == EMIT) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (op == OP_SYMBOL) begin
							state_q <= stat.limit_zero ? DRAIN : SCAN;
						end else begin
							state_q <= EMIT;
						end
					end
				end
				SCAN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if ((cnt_q + CNT_W'(1)) == stat.limit) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					state_q <= EMIT;
				end
				EMIT: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end
endmodule

@@ src/nss_dp.sv @@
// Datapath: config registers, transition table, active set, result register.
// Depends on nss_pkg and nss_ram.
module nss_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  nss_pkg::nss_cmd_t            cmd,
	output nss_pkg::nss_stat_t           stat,
	input  logic                         cfg_we,
	input  logic [nss_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [nss_pkg::CFG_DW-1:0]   cfg_data,
	input  logic [nss_pkg::SLOT_W-1:0]   req_slot,
	input  logic [nss_pkg::STATE_W-1:0]  req_from_state,
	input  logic [nss_pkg::STATE_W-1:0]  req_to_state,
	input  logic [nss_pkg::SYM_W-1:0]    req_entry_symbol,
	input  logic [nss_pkg::SYM_W-1:0]    req_symbol,
	output logic [nss_pkg::STATES-1:0]   out_active_states,
	output logic                         out_accepting,
	output logic                         out_dead
);
	import nss_pkg::*;

	logic [STATE_W-1:0]  initial_q;
	logic [STATES-1:0]   final_q;
	logic [IN_USE_W-1:0] in_use_q;
	logic [SYM_W-1:0]    symbol_q;
	logic [STATES-1:0]   active_q;
	logic                dead_q;
	logic [STATES-1:0]   next_q;
	logic [STATES-1:0]   out_active_q;
	logic                out_accepting_q;
	logic                out_dead_q;

	logic [ENTRY_W-1:0]  rd_data;
	logic [STATE_W-1:0]  e_from;
	logic [STATE_W-1:0]  e_to;
	logic [SYM_W-1:0]    e_sym;
	logic                hit;
	logic [STATES-1:0]   fire_mask;
	logic [STATES-1:0]   next_set;
	logic [STATES-1:0]   init_bit;
	logic [CNT_W-1:0]    limit;
	logic                ram_we;

	always_comb begin
		if (32'(in_use_q) > 32'(TRANSITIONS)) begin
			limit = CNT_W'(TRANSITIONS);
		end else begin
			limit = CNT_W'(in_use_q);
		end
	end
	assign stat.limit      = limit;
	assign stat.limit_zero = (limit == '0);

	assign ram_we = cmd.ram_we && (32'(req_slot) < 32'(TRANSITIONS));

	nss_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TRANSITIONS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(TR_AW'(req_slot)),
		.wdata({req_from_state, req_to_state, req_entry_symbol}),
		.re   (cmd.rd_en),
		.raddr(cmd.rd_addr),
		.rdata(rd_data)
	);

	// entry layout: from | to | symbol
	assign e_from    = rd_data[ENTRY_W-1 -: STATE_W];
	assign e_to      = rd_data[SYM_W +: STATE_W];
	assign e_sym     = rd_data[SYM_W-1:0];
	assign hit       = (|(state_bit(e_from) & active_q)) && (e_sym == symbol_q);
	assign fire_mask = hit ? state_bit(e_to) : '0;
	assign next_set  = next_q | (cmd.eval ? fire_mask : '0);
	assign init_bit  = state_bit(initial_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_q <= '0;
			final_q   <= '0;
			in_use_q  <= '0;
			active_q  <= '0;
			dead_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_addr))
					CFG_INITIAL: initial_q <= cfg_data[STATE_W-1:0];
					CFG_FINAL:   final_q   <= cfg_data[STATES-1:0];
					CFG_IN_USE:  in_use_q  <= cfg_data[IN_USE_W-1:0];
					default: ;
				endcase
			end
			if (cmd.restart) begin
				active_q <= init_bit;
				dead_q   <= (init_bit == '0);
			end else if (cmd.commit) begin
				active_q <= next_set;
				if (next_set == '0) begin
					dead_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			symbol_q <= req_symbol;
			next_q   <= '0;
		end else if (cmd.eval) begin
			next_q <= next_q | fire_mask;
		end
		if (cmd.load_out) begin
			out_active_q    <= active_q;
			out_accepting_q <= |(active_q & final_q);
			out_dead_q      <= dead_q;
		end
	end

	assign out_active_states = out_active_q;
	assign out_accepting     = out_accepting_q;
	assign out_dead          = out_dead_q;
endmodule

@@ src/nfa_symbol_stepper.sv @@
// Channel   Dir   Handshake     Payload
// req       in    valid/ready   opcode, slot, from_state, to_state, entry_symbol, symbol
// rsp       out   valid/ready   active_states, accepting, dead
// cfg       in    valid/ready   addr (register index), data
//
// Write, restart and no-op items go from IDLE straight to EMIT; a symbol item
// scans min(transitions_in_use, 128) entries in SCAN, one table entry per cycle
// through the single read port of the transition RAM, then passes DRAIN and EMIT.
// arst_n clears control state, config registers, active set and dead flag;
// the transition table is not cleared. cfg is always ready.
// The next item is taken while a result waits in the output register;
// a stalled rsp holds the block only when a second result is ready.
// Depends on nss_pkg, nss_if, nss_ctrl, nss_dp, nss_ram.
module nfa_symbol_stepper (
	input  logic      clk,
	input  logic      arst_n,
	nss_req_if.sink   req,
	nss_rsp_if.source rsp,
	nss_cfg_if.sink   cfg
);
	import nss_pkg::*;

	nss_cmd_t  cmd;
	nss_stat_t stat;

	assign cfg.ready = 1'b1;

	nss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_opcode(req.opcode),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	nss_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_we           (cfg.valid),
		.cfg_addr         (cfg.addr),
		.cfg_data         (cfg.data),
		.req_slot         (req.slot),
		.req_from_state   (req.from_state),
		.req_to_state     (req.to_state),
		.req_entry_symbol (req.entry_symbol),
		.req_symbol       (req.symbol),
		.out_active_states(rsp.active_states),
		.out_accepting    (rsp.accepting),
		.out_dead         (rsp.dead)
	);
endmodule

@@ src/nss_checker.sv @@
// Port-level checks for the NFA stepper, bound to the top level.
// Depends on nss_pkg and nfa_symbol_stepper_macros.svh.
`include "nfa_symbol_stepper_macros.svh"

module nss_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [nss_pkg::STATES-1:0]  rsp_active_states,
	input logic                        rsp_accepting,
	input logic                        rsp_dead
);
	import nss_pkg::*;

	`NSS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp valid dropped while stalled")
	`NSS_ASSERT(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "req taken on back-to-back cycles")
	`NSS_ASSERT(a_dead_empty, rsp_valid && rsp_dead |-> rsp_active_states == '0, "dead with active states")
	`NSS_ASSERT_ALWAYS(a_accept_nonempty, rsp_valid && rsp_accepting |-> rsp_active_states != '0, "accepting with empty set")
endmodule

bind nfa_symbol_stepper nss_checker u_nss_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_active_states(rsp.active_states),
	.rsp_accepting    (rsp.accepting),
	.rsp_dead         (rsp.dead)
);

@@ sim/nfa_step_checker.sv @@
`timescale 1ns / 1ps
// Response checker for nfa_symbol_stepper: mirrors the transition table, the active set and
// the registers from observed transactions and checks every response in order.
// Depends on nss_pkg and the nss_if channel interfaces.
module nfa_step_checker (
	input  logic clk,
	input  logic arst_n,
	nss_req_if   req,
	nss_rsp_if   rsp,
	nss_cfg_if   cfg,
	output int   errors,
	output int   pending
);
	import nss_pkg::*;

	typedef struct packed {
		logic [STATE_W-1:0] src;
		logic [STATE_W-1:0] dst;
		logic [SYM_W-1:0]   sym;
	} arc_t;

	typedef struct packed {
		logic [STATES-1:0] set;
		logic              accepting;
		logic              dead;
	} step_result_t;

	arc_t                arcs [TRANSITIONS];
	logic [STATES-1:0]   live_set;
	logic                dead_seen;
	logic [STATE_W-1:0]  start_state;
	logic [STATES-1:0]   accept_mask;
	logic [IN_USE_W-1:0] arcs_in_use;
	step_result_t        predicted_sets [$];
	int                  fail_count = 0;

	assign errors = fail_count;

	function automatic logic [STATES-1:0] state_mask(logic [STATE_W-1:0] s);
		return (int'(s) < STATES) ? ({{(STATES-1){1'b0}}, 1'b1} << s) : '0;
	endfunction

	function automatic step_result_t step_automaton(op_e_t op, logic [SLOT_W-1:0] slot,
			logic [STATE_W-1:0] src, logic [STATE_W-1:0] dst, logic [SYM_W-1:0] esym,
			logic [SYM_W-1:0] sym);
		logic [STATES-1:0] next_set;
		int                scan_len;
		step_result_t      r;
		case (op)
			OP_WRITE: begin
				if (int'(slot) < TRANSITIONS) begin
					arcs[slot] = {src, dst, esym};
				end
			end
			OP_RESTART: begin
				live_set  = state_mask(start_state);
				dead_seen = (live_set == '0);
			end
			OP_SYMBOL: begin
				scan_len = (int'(arcs_in_use) > TRANSITIONS) ? TRANSITIONS : int'(arcs_in_use);
				next_set = '0;
				for (int j = 0; j < scan_len; j++) begin
					if ((live_set & state_mask(arcs[j].src)) != '0 && arcs[j].sym == sym) begin
						next_set |= state_mask(arcs[j].dst);
					end
				end
				live_set = next_set;
				if (next_set == '0) begin
					dead_seen = 1'b1;
				end
			end
			default: ;
		endcase
		r.set       = live_set;
		r.accepting = |(live_set & accept_mask);
		r.dead      = dead_seen;
		return r;
	endfunction

	task automatic flag_mismatch(string what, logic [STATES-1:0] want, logic [STATES-1:0] got);
		$display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		step_result_t want;
		if (!arst_n) begin
			live_set    = '0;
			dead_seen   = 1'b0;
			start_state = '0;
			accept_mask = '0;
			arcs_in_use = '0;
			predicted_sets.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (predicted_sets.size() == 0) begin
					flag_mismatch("response with no transaction outstanding", '0,
						rsp.active_states);
				end else begin
					want = predicted_sets.pop_front();
					if (rsp.active_states !== want.set) begin
						flag_mismatch("active_states", want.set, rsp.active_states);
					end
					if (rsp.accepting !== want.accepting) begin
						flag_mismatch("accepting", STATES'(want.accepting),
							STATES'(rsp.accepting));
					end
					if (rsp.dead !== want.dead) begin
						flag_mismatch("dead", STATES'(want.dead), STATES'(rsp.dead));
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.addr))
					CFG_INITIAL: start_state = cfg.data[STATE_W-1:0];
					CFG_FINAL:   accept_mask = cfg.data[STATES-1:0];
					CFG_IN_USE:  arcs_in_use = cfg.data[IN_USE_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				predicted_sets.push_back(step_automaton(op_e_t'(req.opcode), req.slot,
					req.from_state, req.to_state, req.entry_symbol, req.symbol));
			end
		end
		pending <= predicted_sets.size();
	end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Top of the nfa_symbol_stepper testbench: clock, reset, request and register stimulus,
// response back-pressure, watchdog and verdict; checking lives in nfa_step_checker.
// Depends on nss_pkg, nss_if, nfa_step_checker and the RTL.
module testbench;
	import nss_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 2 * TRANSITIONS + 10;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 75;

	typedef struct packed {
		op_e_t              op;
		logic [SLOT_W-1:0]  slot;
		logic [STATE_W-1:0] src;
		logic [STATE_W-1:0] dst;
		logic [SYM_W-1:0]   esym;
		logic [SYM_W-1:0]   sym;
	} stim_item_t;

	logic             clk;
	logic             arst_n;
	logic             rsp_ready = 1'b0;
	int               err_count;
	int               pending;
	int               quiet_cycles = 0;
	int               send_pct = 0;
	int               stall_pct = 0;
	logic [SYM_W-1:0] alphabet [4];

	nss_req_if req_ch();
	nss_rsp_if rsp_ch();
	nss_cfg_if cfg_ch();

	assign rsp_ch.ready = rsp_ready;

	nfa_symbol_stepper i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	nfa_step_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.cfg     (cfg_ch),
		.errors  (err_count),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	// no transaction on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[nfa_symbol_stepper] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic stim_item_t rand_item();
		stim_item_t it;
		it.op   = op_e_t'($urandom_range(3));
		it.slot = SLOT_W'($urandom);
		it.src  = STATE_W'($urandom);
		it.dst  = STATE_W'($urandom);
		it.esym = SYM_W'($urandom);
		it.sym  = SYM_W'($urandom);
		return it;
	endfunction

	function automatic stim_item_t plain_item(op_e_t op);
		stim_item_t it;
		it    = rand_item();
		it.op = op;
		return it;
	endfunction

	function automatic stim_item_t symbol_item(logic [SYM_W-1:0] sym);
		stim_item_t it;
		it     = plain_item(OP_SYMBOL);
		it.sym = sym;
		return it;
	endfunction

	function automatic stim_item_t write_item(logic [SLOT_W-1:0] slot, logic [STATE_W-1:0] src,
			logic [STATE_W-1:0] dst, logic [SYM_W-1:0] esym);
		stim_item_t it;
		it      = plain_item(OP_WRITE);
		it.slot = slot;
		it.src  = src;
		it.dst  = dst;
		it.esym = esym;
		return it;
	endfunction

	// mostly symbols from the small alphabet so that sets stay alive
	function automatic logic [SYM_W-1:0] entry_letter();
		return ($urandom_range(7) == 0) ? SYM_W'($urandom) : alphabet[$urandom_range(3)];
	endfunction

	task automatic push_req(stim_item_t it);
		if ($urandom_range(99) < send_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_pct);
		end
		req_ch.valid        <= 1'b1;
		req_ch.opcode       <= it.op;
		req_ch.slot         <= it.slot;
		req_ch.from_state   <= it.src;
		req_ch.to_state     <= it.dst;
		req_ch.entry_symbol <= it.esym;
		req_ch.symbol       <= it.sym;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic configure(logic [STATE_W-1:0] init, logic [STATES-1:0] mask,
			logic [IN_USE_W-1:0] in_use);
		cfg_reg_t          idx [3];
		logic [CFG_DW-1:0] val [3];
		idx = '{CFG_INITIAL, CFG_FINAL, CFG_IN_USE};
		val = '{CFG_DW'(init), CFG_DW'(mask), CFG_DW'(in_use)};
		wait_drained();
		for (int k = 0; k < 3; k++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.addr  <= idx[k];
			cfg_ch.data  <= val[k];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_idling(int mode);
		send_pct   = (mode == 1) ? 88 : (mode == 3) ? 11 : 0;
		stall_pct <= (mode == 2) ? 88 : (mode == 3) ? 11 : 0;
	endtask

	initial begin
		stim_item_t          it;
		logic [STATE_W-1:0]  init_st;
		logic [STATES-1:0]   mask;
		logic [IN_USE_W-1:0] in_use;
		int                  n;
		int                  len;
		int                  pick;
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.opcode       <= '0;
		req_ch.slot         <= '0;
		req_ch.from_state   <= '0;
		req_ch.to_state     <= '0;
		req_ch.entry_symbol <= '0;
		req_ch.symbol       <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.addr         <= '0;
		cfg_ch.data         <= '0;
		alphabet = '{8'h00, 8'hFF, SYM_W'($urandom), SYM_W'($urandom)};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: nothing in use, empty set before the first restart
		push_req(symbol_item(8'hFF));
		push_req(plain_item(OP_NOP));
		push_req(plain_item(OP_RESTART));
		push_req(symbol_item(8'h00));
		push_req(plain_item(OP_RESTART));
		push_req(write_item(7'd0, 4'd0, STATE_W'(STATES-1), 8'h00));
		push_req(write_item(7'd1, STATE_W'(STATES-1), 4'd0, 8'hFF));
		push_req(write_item(7'd2, 4'd0, 4'd0, 8'hFF));
		push_req(write_item(7'd3, STATE_W'(STATES-1), STATE_W'(STATES-1), 8'h00));
		push_req(write_item(SLOT_W'(TRANSITIONS-1), STATE_W'(STATES-1), 4'd0, 8'hFF));
		for (int s = 4; s < TRANSITIONS - 1; s++) begin
			push_req(write_item(SLOT_W'(s), STATE_W'($urandom), STATE_W'($urandom),
				entry_letter()));
		end

		configure(4'd0, STATES'(1) << (STATES - 1), IN_USE_W'(4));
		push_req(plain_item(OP_RESTART));
		push_req(symbol_item(8'h00));
		push_req(symbol_item(8'h00));
		push_req(symbol_item(8'hFF));
		push_req(symbol_item(8'h55));
		push_req(symbol_item(8'h00));
		push_req(plain_item(OP_RESTART));
		push_req(plain_item(OP_NOP));

		// in-use count above the table size saturates
		configure(STATE_W'(STATES-1), '1, '1);
		push_req(plain_item(OP_RESTART));
		push_req(symbol_item(8'hFF));
		push_req(symbol_item(8'h00));
		push_req(symbol_item(8'hFF));

		configure(STATE_W'(STATES-1), '0, IN_USE_W'(1));
		push_req(plain_item(OP_RESTART));
		push_req(symbol_item(8'h00));

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				init_st = '0;
				mask    = '0;
				in_use  = IN_USE_W'(TRANSITIONS);
			end else if (p == 1) begin
				init_st = STATE_W'(STATES-1);
				mask    = '1;
				in_use  = '1;
			end else begin
				init_st = STATE_W'($urandom);
				mask    = STATES'($urandom);
				if ($urandom_range(3) == 0) begin
					in_use = IN_USE_W'($urandom_range(17, TRANSITIONS));
				end else begin
					in_use = IN_USE_W'($urandom_range(1, 16));
				end
			end
			configure(init_st, mask, in_use);
			set_idling(p % 4);
			n = 0;
			while (n < PHASE_ITEMS) begin
				push_req(plain_item(OP_RESTART));
				n++;
				len = $urandom_range(1, 10);
				for (int k = 0; k < len; k++) begin
					pick = $urandom_range(99);
					if (pick < 80) begin
						it = symbol_item(alphabet[$urandom_range(3)]);
					end else if (pick < 88) begin
						it = symbol_item(SYM_W'($urandom));
					end else if (pick < 94) begin
						it = write_item(SLOT_W'($urandom), STATE_W'($urandom),
							STATE_W'($urandom), entry_letter());
					end else if (pick < 97) begin
						it = plain_item(OP_NOP);
					end else begin
						it = rand_item();
					end
					push_req(it);
					n++;
				end
				if ($urandom_range(15) == 0) begin
					wait_drained();
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && pending == 0) begin
			$display("[nfa_symbol_stepper] OK");
		end else begin
			$display("[nfa_symbol_stepper] ERROR");
		end
		$finish;
	end

endmodule

@@ nfa_symbol_stepper.f @@
+incdir+src
src/nss_pkg.sv
src/nss_if.sv
src/nss_ram.sv
src/nss_ctrl.sv
src/nss_dp.sv
src/nfa_symbol_stepper.sv
src/nss_checker.sv
sim/nfa_step_checker.sv
sim/testbench.sv
